// ----- rtl/lprl_pkg.sv -----
// Package for the longest prefix route lookup core: table sizes, the stored
// route word layout and the mask length function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lprl_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int PORT_COUNT    = 16;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   localparam int ADDR_W = 32;
   localparam int PORT_W = 4;
   localparam int LEN_W  = 6;
   localparam int SLOT_W = 4;

   // Command codes carried on the action field of a word.
   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_WRITE  = 1'b1;

   // One stored route; the mask length is worked out when the route is written.
   typedef struct packed {
      logic [ADDR_W-1:0] prefix;
      logic [ADDR_W-1:0] mask;
      logic [PORT_W-1:0] port;
      logic [LEN_W-1:0]  len;
   } route_entry_type;

   localparam int ENTRY_W = $bits(route_entry_type);

   // Controls from the sequencer to the match selector.
   typedef struct packed {
      logic             clear;
      logic             eval;
      logic [IDX_W-1:0] idx;
   } scan_ctrl_type;

   // Count of set bits: nibble counts first, then a short sum over eight nibbles.
   function automatic logic [LEN_W-1:0] mask_length(input logic [ADDR_W-1:0] m);
      logic [2:0]       nib [8];
      logic [LEN_W-1:0] sum;
      for (int n = 0; n < 8; n++) begin
         nib[n] = {2'b00, m[4*n]} + {2'b00, m[4*n+1]} + {2'b00, m[4*n+2]}
                + {2'b00, m[4*n+3]};
      end
      sum = '0;
      for (int n = 0; n < 8; n++) begin
         sum = sum + {3'b000, nib[n]};
      end
      return sum;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/lprl_route_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM with a registered
// read port. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lprl_route_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 74,
   parameter int AW    = 4
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/lprl_best_sel.sv -----
// Match selector: tests one route word a cycle while eval is set against the
// destination and keeps the longest match so far. Depends on lprl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lprl_best_sel (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire lprl_pkg::scan_ctrl_type         ctrl,
   input  wire logic [lprl_pkg::ADDR_W-1:0]     dest_addr,
   input  wire lprl_pkg::route_entry_type       entry,
   input  wire logic                            entry_valid,
   output logic                                 hit,
   output logic      [lprl_pkg::PORT_W-1:0]     best_port,
   output logic      [lprl_pkg::IDX_W-1:0]      best_idx,
   output logic      [lprl_pkg::LEN_W-1:0]      best_len
);
   import lprl_pkg::*;

   logic             hit_ff,  hit_in;
   logic [PORT_W-1:0] port_ff, port_in;
   logic [IDX_W-1:0] idx_ff,  idx_in;
   logic [LEN_W-1:0] len_ff,  len_in;
   logic             match;
   logic             take;

   assign match = entry_valid && (((dest_addr ^ entry.prefix) & entry.mask) == '0);
   // Strictly longer replaces, so the lowest slot keeps a tie.
   assign take  = ctrl.eval && match && (!hit_ff || (entry.len > len_ff));

   always_comb begin
      hit_in  = hit_ff;
      port_in = port_ff;
      idx_in  = idx_ff;
      len_in  = len_ff;
      if (ctrl.clear) begin
         hit_in  = 1'b0;
         port_in = '0;
         idx_in  = '0;
         len_in  = '0;
      end else if (take) begin
         hit_in  = 1'b1;
         port_in = entry.port;
         idx_in  = ctrl.idx;
         len_in  = entry.len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         port_ff <= '0;
         idx_ff  <= '0;
         len_ff  <= '0;
      end else begin
         hit_ff  <= hit_in;
         port_ff <= port_in;
         idx_ff  <= idx_in;
         len_ff  <= len_in;
      end
   end

   assign hit       = hit_ff;
   assign best_port = port_ff;
   assign best_idx  = idx_ff;
   assign best_len  = len_ff;

   // A hit never reports a length that no mask can have.
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      hit_ff |-> (len_ff <= LEN_W'(ADDR_W)))
      else $error("best length out of range");

   // Without a hit the best registers stay at zero.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      !hit_ff |-> (len_ff == '0 && port_ff == '0 && idx_ff == '0))
      else $error("best registers set without a hit");

   // A clear always empties the selector on the next cycle.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear |=> !hit_ff)
      else $error("clear did not drop the hit");

endmodule

`default_nettype wire

// ----- rtl/longest_prefix_route_lookup_core.sv -----
// Top level of the longest prefix route lookup core: command port, scan
// sequencer, valid bits and the route memory. Depends on lprl_pkg,
// lprl_route_ram and lprl_best_sel.
// Results: a write word gives its result in the cycle after it is taken; a lookup
// scans every slot, then passes a drain state and a done state before its result.
// Throughput: one word at a time; busy is high from the accepting edge until
// the result cycle ends. The scan reads one route per cycle from the memory
// port, which sets the lookup time. The receiver cannot stall the result.
// Reset (synchronous) marks every route invalid at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module longest_prefix_route_lookup_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_action,
   input  wire logic [lprl_pkg::ADDR_W-1:0] req_dest_addr,
   input  wire logic [lprl_pkg::SLOT_W-1:0] req_entry_index,
   input  wire logic [lprl_pkg::ADDR_W-1:0] req_entry_prefix,
   input  wire logic [lprl_pkg::ADDR_W-1:0] req_entry_mask,
   input  wire logic [lprl_pkg::PORT_W-1:0] req_entry_port,
   input  wire logic                        req_entry_valid,
   output logic                             rsp_strobe,
   output logic                             rsp_found,
   output logic      [lprl_pkg::PORT_W-1:0] rsp_out_port,
   output logic      [lprl_pkg::SLOT_W-1:0] rsp_match_index,
   output logic      [lprl_pkg::LEN_W-1:0]  rsp_match_length
);
   import lprl_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_DONE  = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   logic [2:0]         state_ff, state_in;
   logic [IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic               eval_ff;
   logic [IDX_W-1:0]   eval_idx_ff;
   logic               rd_valid_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;

   // Captured word.
   logic [ADDR_W-1:0]  addr_ff;
   logic [IDX_W-1:0]   wr_idx_ff;
   logic [ADDR_W-1:0]  wr_prefix_ff;
   logic [ADDR_W-1:0]  wr_mask_ff;
   logic [PORT_W-1:0]  wr_port_ff;
   logic               wr_valid_ff;
   logic               wr_ok_ff;

   logic               accept;
   logic               issue;
   logic               ram_we;
   route_entry_type    wr_entry;
   logic [ENTRY_W-1:0] rd_word;
   route_entry_type    rd_entry;
   scan_ctrl_type      ctrl;
   logic               hit;
   logic [PORT_W-1:0]  best_port;
   logic [IDX_W-1:0]   best_idx;
   logic [LEN_W-1:0]   best_len;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign issue  = (state_ff == ST_SCAN);
   assign ram_we = (state_ff == ST_WRITE) && wr_ok_ff;

   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in    = (req_action == ACT_WRITE) ? ST_WRITE : ST_SCAN;
               scan_idx_in = '0;
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         ST_WRITE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         scan_idx_ff <= '0;
         eval_ff     <= 1'b0;
         valid_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         scan_idx_ff <= scan_idx_in;
         eval_ff     <= issue;
         if (ram_we) begin
            valid_ff[wr_idx_ff] <= wr_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff      <= req_dest_addr;
         wr_idx_ff    <= IDX_W'(req_entry_index);
         wr_prefix_ff <= req_entry_prefix;
         wr_mask_ff   <= req_entry_mask;
         wr_port_ff   <= req_entry_port;
         wr_valid_ff  <= req_entry_valid;
         // Writes to a missing slot or an unknown port leave the table alone.
         wr_ok_ff     <= (32'(req_entry_index) < TABLE_ENTRIES)
                      && (32'(req_entry_port) < PORT_COUNT);
      end
      eval_idx_ff <= scan_idx_ff;
      rd_valid_ff <= valid_ff[scan_idx_ff];
   end

   always_comb begin
      wr_entry.prefix = wr_prefix_ff;
      wr_entry.mask   = wr_mask_ff;
      wr_entry.port   = wr_port_ff;
      wr_entry.len    = mask_length(wr_mask_ff);
   end

   lprl_route_ram #(
      .DEPTH (TABLE_ENTRIES),
      .WIDTH (ENTRY_W),
      .AW    (IDX_W)
   ) u_ram (
      .clock   (clock),
      .we      (ram_we),
      .wr_addr (wr_idx_ff),
      .wr_data (wr_entry),
      .rd_en   (issue),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_word)
   );

   assign rd_entry   = route_entry_type'(rd_word);
   assign ctrl.clear = accept;
   assign ctrl.eval  = eval_ff;
   assign ctrl.idx   = eval_idx_ff;

   lprl_best_sel u_best (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .dest_addr   (addr_ff),
      .entry       (rd_entry),
      .entry_valid (rd_valid_ff),
      .hit         (hit),
      .best_port   (best_port),
      .best_idx    (best_idx),
      .best_len    (best_len)
   );

   // A write word answers with all zeros; the selector was cleared at accept.
   assign rsp_strobe       = (state_ff == ST_DONE) || (state_ff == ST_WRITE);
   assign rsp_found        = (state_ff == ST_DONE) && hit;
   assign rsp_out_port     = (state_ff == ST_DONE) ? best_port : '0;
   assign rsp_match_index  = (state_ff == ST_DONE) ? SLOT_W'(best_idx) : '0;
   assign rsp_match_length = (state_ff == ST_DONE) ? best_len : '0;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("word taken but busy not raised");

   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("result not followed by idle");

   a_rsp_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside a busy cycle");

   a_write_no_eval: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !eval_ff && !issue)
      else $error("table write overlaps a scan");

endmodule

`default_nettype wire

// ----- tb/sv/tb_longest_prefix_route_lookup_core.sv -----
// Testbench for longest_prefix_route_lookup_core: a directed table of route writes
// and lookups, then random traffic, checked against a predictor of the route table
// or, for some directed rows, a hand-written result. Depends on lprl_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_longest_prefix_route_lookup_core;
   import lprl_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RANDOM_WORDS   = 1730;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int DRAIN_CYCLES   = TABLE_ENTRIES + 6;

   typedef struct packed {
      logic              action;
      logic [ADDR_W-1:0] dest_addr;
      logic [SLOT_W-1:0] entry_index;
      logic [ADDR_W-1:0] entry_prefix;
      logic [ADDR_W-1:0] entry_mask;
      logic [PORT_W-1:0] entry_port;
      logic              entry_valid;
   } route_cmd_type;

   typedef struct packed {
      logic              found;
      logic [PORT_W-1:0] out_port;
      logic [SLOT_W-1:0] match_index;
      logic [LEN_W-1:0]  match_length;
   } route_result_type;

   typedef struct packed {
      route_cmd_type    cmd;
      logic             fixed_exp;
      route_result_type res;
   } directed_row_type;

   localparam route_result_type NO_ROUTE = '0;
   localparam int NUM_DIRECTED = 20;

   // Rows with fixed_exp set carry a hand-written result; the rest go to the predictor.
   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{'{ACT_LOOKUP, 32'h0000_0000, 4'd0, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b1, NO_ROUTE},
      '{'{ACT_LOOKUP, 32'hFFFF_FFFF, 4'd0, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b1, NO_ROUTE},
      '{'{ACT_WRITE, 32'h1357_9BDF, 4'd0, 32'h0000_0000, 32'h0000_0000, 4'd5, 1'b1},
        1'b1, NO_ROUTE},
      '{'{ACT_LOOKUP, 32'h1234_5678, 4'd0, 32'h0, 32'h0, 4'd0, 1'b0},
        1'b1, '{1'b1, 4'd5, 4'd0, 6'd0}},
      '{'{ACT_WRITE, 32'h0, 4'd15, 32'hC0A8_0100, 32'hFFFF_FF00, 4'd15, 1'b1},
        1'b1, NO_ROUTE},
      '{'{ACT_LOOKUP, 32'hC0A8_0123, 4'd0, 32'h0, 32'h0, 4'd0, 1'b0},
        1'b1, '{1'b1, 4'd15, 4'd15, 6'd24}},
      '{'{ACT_WRITE, 32'h0, 4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd1, 1'b1},
        1'b1, NO_ROUTE},
      '{'{ACT_LOOKUP, 32'hFFFF_FFFF, 4'd0, 32'h0, 32'h0, 4'd0, 1'b0},
        1'b1, '{1'b1, 4'd1, 4'd3, 6'd32}},
      '{'{ACT_LOOKUP, 32'hFFFF_FFFE, 4'd0, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b0, NO_ROUTE},
      '{'{ACT_WRITE, 32'h0, 4'd7, 32'hC0A8_01FF, 32'hFFFF_FF00, 4'd2, 1'b1},
        1'b1, NO_ROUTE},
      '{'{ACT_LOOKUP, 32'hC0A8_01FF, 4'd0, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b0, NO_ROUTE},
      '{'{ACT_WRITE, 32'h0, 4'd7, 32'hC0A8_0100, 32'hFFFF_FF00, 4'd2, 1'b0},
        1'b1, NO_ROUTE},
      '{'{ACT_LOOKUP, 32'hC0A8_0180, 4'd0, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b0, NO_ROUTE},
      '{'{ACT_WRITE, 32'h0, 4'd9, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 4'd9, 1'b1},
        1'b1, NO_ROUTE},
      '{'{ACT_LOOKUP, 32'h5A5A_5A5A, 4'd0, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b0, NO_ROUTE},
      '{'{ACT_WRITE, 32'h0, 4'd0, 32'h0000_0000, 32'h0000_0000, 4'd0, 1'b0},
        1'b1, NO_ROUTE},
      '{'{ACT_LOOKUP, 32'h0000_0000, 4'd0, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b0, NO_ROUTE},
      '{'{ACT_WRITE, 32'h0, 4'd8, 32'h8000_0000, 32'h8000_0000, 4'd0, 1'b1},
        1'b1, NO_ROUTE},
      '{'{ACT_LOOKUP, 32'h8000_0001, 4'd0, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b0, NO_ROUTE},
      '{'{ACT_LOOKUP, 32'h7FFF_FFFF, 4'd0, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b0, NO_ROUTE}
   };

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_action;
   logic [ADDR_W-1:0] req_dest_addr;
   logic [SLOT_W-1:0] req_entry_index;
   logic [ADDR_W-1:0] req_entry_prefix;
   logic [ADDR_W-1:0] req_entry_mask;
   logic [PORT_W-1:0] req_entry_port;
   logic              req_entry_valid;
   logic              rsp_strobe;
   logic              rsp_found;
   logic [PORT_W-1:0] rsp_out_port;
   logic [SLOT_W-1:0] rsp_match_index;
   logic [LEN_W-1:0]  rsp_match_length;

   // Shadow copy of the route table.
   logic [ADDR_W-1:0] rt_prefix [TABLE_ENTRIES];
   logic [ADDR_W-1:0] rt_mask   [TABLE_ENTRIES];
   logic [PORT_W-1:0] rt_port   [TABLE_ENTRIES];
   logic              rt_valid  [TABLE_ENTRIES];

   route_result_type pending_results [$];
   int               error_count  = 0;
   int               quiet_cycles = 0;

   longest_prefix_route_lookup_core uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_dest_addr    (req_dest_addr),
      .req_entry_index  (req_entry_index),
      .req_entry_prefix (req_entry_prefix),
      .req_entry_mask   (req_entry_mask),
      .req_entry_port   (req_entry_port),
      .req_entry_valid  (req_entry_valid),
      .rsp_strobe       (rsp_strobe),
      .rsp_found        (rsp_found),
      .rsp_out_port     (rsp_out_port),
      .rsp_match_index  (rsp_match_index),
      .rsp_match_length (rsp_match_length)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Applies one accepted word to the shadow table and returns the result it yields.
   function automatic route_result_type lookup_best_route(input route_cmd_type c);
      route_result_type r;
      int               len;
      r = NO_ROUTE;
      if (c.action == ACT_WRITE) begin
         if (int'(c.entry_index) < TABLE_ENTRIES && int'(c.entry_port) < PORT_COUNT) begin
            rt_prefix[c.entry_index] = c.entry_prefix;
            rt_mask[c.entry_index]   = c.entry_mask;
            rt_port[c.entry_index]   = c.entry_port;
            rt_valid[c.entry_index]  = c.entry_valid;
         end
      end else begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (rt_valid[i] && ((c.dest_addr & rt_mask[i]) == (rt_prefix[i] & rt_mask[i])))
            begin
               len = $countones(rt_mask[i]);
               // Strictly longer only, so the lowest slot keeps a tie.
               if (!r.found || len > int'(r.match_length)) begin
                  r.found        = 1'b1;
                  r.out_port     = rt_port[i];
                  r.match_index  = SLOT_W'(i);
                  r.match_length = LEN_W'(len);
               end
            end
         end
      end
      return r;
   endfunction

   // Most lookups aim inside a stored route so that matches, ties and nesting occur;
   // prefixes often share a high half so that routes overlap.
   function automatic route_cmd_type random_route_cmd();
      route_cmd_type c;
      int            slot;
      int            plen;
      c.action       = ($urandom_range(0, 99) < 35) ? ACT_WRITE : ACT_LOOKUP;
      c.dest_addr    = $urandom();
      c.entry_index  = SLOT_W'($urandom_range(0, 15));
      c.entry_prefix = $urandom();
      c.entry_port   = PORT_W'($urandom_range(0, 15));
      c.entry_valid  = ($urandom_range(0, 99) < 85);
      plen = ($urandom_range(0, 3) == 0) ? 8 * $urandom_range(0, 4) : $urandom_range(0, 32);
      c.entry_mask = ($urandom_range(0, 4) == 0) ? $urandom() : 32'hFFFF_FFFF << (32 - plen);
      if ($urandom_range(0, 1) == 1) begin
         c.entry_prefix[31:16] = 16'hC0A8;
      end
      if (c.action == ACT_LOOKUP && $urandom_range(0, 99) < 70) begin
         slot = $urandom_range(0, TABLE_ENTRIES - 1);
         c.dest_addr = (rt_prefix[slot] & rt_mask[slot]) | (c.dest_addr & ~rt_mask[slot]);
      end
      return c;
   endfunction

   // Result checker and watchdog.
   always @(posedge clock) begin
      route_result_type exp_res;
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               $error("result word with no lookup or write outstanding");
               error_count++;
            end else begin
               exp_res = pending_results.pop_front();
               if (rsp_found !== exp_res.found) begin
                  $error("found: expected %0d, got %0d", exp_res.found, rsp_found);
                  error_count++;
               end
               if (rsp_out_port !== exp_res.out_port) begin
                  $error("out_port: expected %0d, got %0d", exp_res.out_port, rsp_out_port);
                  error_count++;
               end
               if (rsp_match_index !== exp_res.match_index) begin
                  $error("match_index: expected %0d, got %0d",
                         exp_res.match_index, rsp_match_index);
                  error_count++;
               end
               if (rsp_match_length !== exp_res.match_length) begin
                  $error("match_length: expected %0d, got %0d",
                         exp_res.match_length, rsp_match_length);
                  error_count++;
               end
            end
         end
         if (rsp_strobe || (start && !busy)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Word driver: bursts of back-to-back words separated by random gaps.
   initial begin
      route_cmd_type    cmd;
      route_result_type res;
      int               burst_left;
      int               gap;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         rt_prefix[i] = '0;
         rt_mask[i]   = '0;
         rt_port[i]   = '0;
         rt_valid[i]  = 1'b0;
      end
      reset            = 1'b1;
      start            = 1'b0;
      req_action       = ACT_LOOKUP;
      req_dest_addr    = '0;
      req_entry_index  = '0;
      req_entry_prefix = '0;
      req_entry_mask   = '0;
      req_entry_port   = '0;
      req_entry_valid  = 1'b0;
      burst_left       = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int n = 0; n < NUM_DIRECTED + RANDOM_WORDS; n++) begin
         cmd = (n < NUM_DIRECTED) ? directed_rows[n].cmd : random_route_cmd();
         gap = 0;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         end
         burst_left--;
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         start            <= 1'b1;
         req_action       <= cmd.action;
         req_dest_addr    <= cmd.dest_addr;
         req_entry_index  <= cmd.entry_index;
         req_entry_prefix <= cmd.entry_prefix;
         req_entry_mask   <= cmd.entry_mask;
         req_entry_port   <= cmd.entry_port;
         req_entry_valid  <= cmd.entry_valid;
         do @(posedge clock); while (busy);
         res = lookup_best_route(cmd);
         if (n < NUM_DIRECTED && directed_rows[n].fixed_exp) begin
            res = directed_rows[n].res;
         end
         pending_results.push_back(res);
      end
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/lprl_pkg.sv
rtl/lprl_route_ram.sv
rtl/lprl_best_sel.sv
rtl/longest_prefix_route_lookup_core.sv
tb/sv/tb_longest_prefix_route_lookup_core.sv
